// ===== hw/rtl/cst_pkg.sv =====
package cst_pkg;

	// Result codes
	typedef enum logic [1:0] {
		ST_UPDATED      = 2'd0,
		ST_OUT_OF_ORDER = 2'd1,
		ST_INSERTED     = 2'd2,
		ST_TABLE_FULL   = 2'd3
	} status_t;

	localparam logic [15:0] EXPIRY_RESET = 16'd120;

	// Lookup word that walks the cell row
	typedef struct packed {
		logic        valid;
		logic [31:0] addr;
		logic [15:0] port;
		logic [31:0] seq;
		logic [31:0] now;
		logic        found;
		status_t     status;
		logic [31:0] reported;
		logic        free_found;
	} tok_t;

	// Insert command broadcast to every cell
	typedef struct packed {
		logic        en;
		logic [31:0] addr;
		logic [15:0] port;
		logic [31:0] seq;
		logic [31:0] now;
	} ins_t;

endpackage

// ===== hw/rtl/client_sequence_tracker_core.sv =====
// An accepted word passes the head register, one register per cell and the tail
// register; the lookup walks the cell row one entry per cycle. The word waits
// in the tail for a free output; its commit does the insert and frees the input.
// A finished result waits in the output register while the next word is taken.
// Reset clears all entry valid bits and loads the expiry register with 120.
module client_sequence_tracker_core #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] client_addr,
	input  logic [15:0] client_port,
	input  logic signed [31:0] sequence_req,
	input  logic [31:0] now_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic signed [31:0] stored_sequence,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic [15:0]        expiry_q;
	logic               busy_q;
	cst_pkg::tok_t      head_tok_q;
	cst_pkg::tok_t      tail_tok_q;
	logic [IDX_W-1:0]   tail_idx_q;
	logic               out_valid_q;
	cst_pkg::status_t   status_q;
	logic [31:0]        stored_q;

	cst_pkg::tok_t      chain_tok [TABLE_ENTRIES+1];
	logic [IDX_W-1:0]   chain_idx [TABLE_ENTRIES+1];
	logic [TABLE_ENTRIES+1:0] tok_vld;

	logic               accept;
	logic               commit;
	cst_pkg::ins_t      ins;
	cst_pkg::status_t   status_nx;
	logic [31:0]        stored_nx;

	assign in_ready        = !busy_q;
	assign accept          = in_valid && !busy_q;
	assign commit          = tail_tok_q.valid && (!out_valid_q || out_ready);
	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign stored_sequence = stored_q;

	assign chain_tok[0] = head_tok_q;
	assign chain_idx[0] = '0;

	// Cell row
	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		cst_cell #(
			.CELL_INDEX(i),
			.IDX_W     (IDX_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.expiry  (expiry_q),
			.prev_tok(chain_tok[i]),
			.prev_idx(chain_idx[i]),
			.next_tok(chain_tok[i+1]),
			.next_idx(chain_idx[i+1]),
			.ins     (ins),
			.ins_idx (tail_idx_q)
		);
	end

	for (genvar j = 0; j <= TABLE_ENTRIES; j++) begin : g_vld
		assign tok_vld[j] = chain_tok[j].valid;
	end
	assign tok_vld[TABLE_ENTRIES+1] = tail_tok_q.valid;

	// Resolve the final result and the insert
	always_comb begin
		ins.en   = commit && !tail_tok_q.found && tail_tok_q.free_found;
		ins.addr = tail_tok_q.addr;
		ins.port = tail_tok_q.port;
		ins.seq  = tail_tok_q.seq;
		ins.now  = tail_tok_q.now;
		if (tail_tok_q.found) begin
			status_nx = tail_tok_q.status;
			stored_nx = tail_tok_q.reported;
		end else if (tail_tok_q.free_found) begin
			status_nx = cst_pkg::ST_INSERTED;
			stored_nx = tail_tok_q.seq;
		end else begin
			status_nx = cst_pkg::ST_TABLE_FULL;
			stored_nx = tail_tok_q.seq;
		end
	end

	// Expiry register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expiry_q <= cst_pkg::EXPIRY_RESET;
		end else if (cfg_we) begin
			expiry_q <= cfg_wdata;
		end
	end

	// Launch a word into the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_tok_q <= '0;
		end else begin
			head_tok_q.valid <= accept;
			if (accept) begin
				head_tok_q.addr       <= client_addr;
				head_tok_q.port       <= client_port;
				head_tok_q.seq        <= sequence_req;
				head_tok_q.now        <= now_seconds;
				head_tok_q.found      <= 1'b0;
				head_tok_q.status     <= cst_pkg::ST_UPDATED;
				head_tok_q.reported   <= sequence_req;
				head_tok_q.free_found <= 1'b0;
			end
		end
	end

	// Hold the word at the end of the row until the output is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_tok_q <= '0;
			tail_idx_q <= '0;
		end else if (chain_tok[TABLE_ENTRIES].valid) begin
			tail_tok_q <= chain_tok[TABLE_ENTRIES];
			tail_idx_q <= chain_idx[TABLE_ENTRIES];
		end else if (commit) begin
			tail_tok_q.valid <= 1'b0;
		end
	end

	// Busy from accept until the result is committed to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (commit) begin
			busy_q <= 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= status_nx;
			stored_q <= stored_nx;
		end
	end

	// At most one word in flight
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one lookup word in flight");

	// Idle means the row and tail are empty
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (tok_vld == '0))
		else $error("lookup word present while idle");

	// A commit always ends a busy period
	a_commit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> busy_q ##1 !busy_q)
		else $error("commit outside a busy period");

	// An accepted word is launched into the row on the next cycle
	a_walk: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> head_tok_q.valid)
		else $error("accepted word not launched");

endmodule

// ===== hw/rtl/cst_cell.sv =====
module cst_cell #(
	parameter int CELL_INDEX = 0,
	parameter int IDX_W = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         expiry,
	input  cst_pkg::tok_t       prev_tok,
	input  logic [IDX_W-1:0]    prev_idx,
	output cst_pkg::tok_t       next_tok,
	output logic [IDX_W-1:0]    next_idx,
	input  cst_pkg::ins_t       ins,
	input  logic [IDX_W-1:0]    ins_idx
);

	logic        valid_q;
	logic [31:0] addr_q;
	logic [15:0] port_q;
	logic [31:0] seq_q;
	logic [31:0] time_q;

	logic [31:0]   age;
	logic          stale;
	logic          hit;
	logic          ooo;
	logic          ins_here;
	cst_pkg::tok_t tok_nx;
	logic [IDX_W-1:0] idx_nx;

	// Examine the entry against the passing word
	always_comb begin
		age      = prev_tok.now - time_q;
		stale    = (age >= {16'd0, expiry});
		hit      = valid_q && (addr_q == prev_tok.addr) && (port_q == prev_tok.port);
		ooo      = hit && !stale && ($signed(seq_q) > $signed(prev_tok.seq));
		ins_here = ins.en && (ins_idx == IDX_W'(CELL_INDEX));
		tok_nx   = prev_tok;
		idx_nx   = prev_idx;
		if (hit) begin
			tok_nx.found = 1'b1;
			if (ooo) begin
				tok_nx.status   = cst_pkg::ST_OUT_OF_ORDER;
				tok_nx.reported = seq_q;
			end else begin
				tok_nx.status   = cst_pkg::ST_UPDATED;
				tok_nx.reported = prev_tok.seq;
			end
		end
		// Remember the first free slot seen
		if (!valid_q && !prev_tok.free_found) begin
			tok_nx.free_found = 1'b1;
			idx_nx            = IDX_W'(CELL_INDEX);
		end
	end

	// Hand the word to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_tok <= '0;
			next_idx <= '0;
		end else begin
			next_tok <= tok_nx;
			next_idx <= idx_nx;
		end
	end

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ins_here) begin
			valid_q <= 1'b1;
		end
	end

	// Entry contents: insert, update on a hit that is not out of order, refresh a stale entry on a miss
	always_ff @(posedge clk) begin
		if (ins_here) begin
			addr_q <= ins.addr;
			port_q <= ins.port;
			seq_q  <= ins.seq;
			time_q <= ins.now;
		end else if (prev_tok.valid && valid_q) begin
			if (hit && !ooo) begin
				time_q <= prev_tok.now;
				seq_q  <= prev_tok.seq;
			end else if (!hit && stale) begin
				time_q <= prev_tok.now;
				seq_q  <= 32'd0;
			end
		end
	end

endmodule

// ===== sim/tb_client_sequence_tracker_core.sv =====
module tb_client_sequence_tracker_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES     = 16;
	localparam int DRAIN_WAIT  = ENTRIES + 6;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 210;

	typedef struct {
		logic [31:0]        addr;
		logic [15:0]        port;
		logic signed [31:0] seq;
		logic [31:0]        now;
	} packet_t;

	typedef struct {
		cst_pkg::status_t   status;
		logic signed [31:0] seq;
	} verdict_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic [31:0]        client_addr = '0;
	logic [15:0]        client_port = '0;
	logic signed [31:0] sequence_req = '0;
	logic [31:0]        now_seconds = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic [1:0]         status;
	logic signed [31:0] stored_sequence;
	logic               cfg_we      = 1'b0;
	logic [15:0]        cfg_wdata   = '0;

	// Shadow of the client table and the expiry register
	logic               tbl_used [ENTRIES] = '{default: 1'b0};
	logic [31:0]        tbl_addr [ENTRIES];
	logic [15:0]        tbl_port [ENTRIES];
	logic signed [31:0] tbl_seq  [ENTRIES];
	logic [31:0]        tbl_time [ENTRIES];
	logic [15:0]        expiry_model = cst_pkg::EXPIRY_RESET;

	packet_t  packet_q[$];
	verdict_t verdict_q[$];

	int error_count  = 0;
	int cycle_count  = 0;
	int results_seen = 0;
	int hold_left    = 0;
	int pat_age      = 0;
	logic [7:0] ready_pat = 8'hFF;
	int gap_left;
	int burst_left;

	// Stimulus-side view of the clients that were put in the table
	logic [31:0]        roster_addr [ENTRIES];
	logic [15:0]        roster_port [ENTRIES];
	logic signed [31:0] roster_seq  [ENTRIES];
	logic [31:0]        clock_s;

	client_sequence_tracker_core #(
		.TABLE_ENTRIES(ENTRIES)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.client_addr    (client_addr),
		.client_port    (client_port),
		.sequence_req   (sequence_req),
		.now_seconds    (now_seconds),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.stored_sequence(stored_sequence),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic aged_out(input logic [31:0] now, input logic [31:0] then_s);
		logic [31:0] age;
		age = now - then_s;
		return age >= {16'd0, expiry_model};
	endfunction

	// Walk the shadow table for one packet and queue the verdict it earns
	function automatic void track_packet(input logic [31:0] addr, input logic [15:0] port,
			input logic signed [31:0] seq, input logic [31:0] now);
		verdict_t v;
		logic     hit;
		logic     placed;
		int       i;
		v.status = cst_pkg::ST_UPDATED;
		v.seq    = seq;
		hit      = 1'b0;
		placed   = 1'b0;
		for (i = 0; i < ENTRIES; i++) begin
			if (tbl_used[i]) begin
				if (tbl_addr[i] == addr && tbl_port[i] == port) begin
					hit = 1'b1;
					if (!aged_out(now, tbl_time[i]) && tbl_seq[i] > seq) begin
						v.status = cst_pkg::ST_OUT_OF_ORDER;
						v.seq    = tbl_seq[i];
					end else begin
						tbl_time[i] = now;
						tbl_seq[i]  = seq;
						v.status    = cst_pkg::ST_UPDATED;
						v.seq       = seq;
					end
				end else if (aged_out(now, tbl_time[i])) begin
					tbl_time[i] = now;
					tbl_seq[i]  = '0;
				end
			end
		end
		if (!hit) begin
			v.status = cst_pkg::ST_TABLE_FULL;
			v.seq    = seq;
			for (i = 0; i < ENTRIES; i++) begin
				if (!placed && !tbl_used[i]) begin
					tbl_used[i] = 1'b1;
					tbl_addr[i] = addr;
					tbl_port[i] = port;
					tbl_seq[i]  = seq;
					tbl_time[i] = now;
					v.status    = cst_pkg::ST_INSERTED;
					placed      = 1'b1;
				end
			end
		end
		verdict_q.push_back(v);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
		error_count++;
	endtask

	// Sender: offer queued words in bursts separated by random gaps
	always @(posedge clk or negedge arst_n) begin : drive_proc
		packet_t pkt;
		logic    offer;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			gap_left   <= 0;
			burst_left <= 1;
		end else begin
			offer = in_valid;
			if (in_valid && in_ready) begin
				track_packet(client_addr, client_port, sequence_req, now_seconds);
				offer = 1'b0;
			end
			if (!offer) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
				end else if (packet_q.size() != 0) begin
					pkt = packet_q.pop_front();
					client_addr  <= pkt.addr;
					client_port  <= pkt.port;
					sequence_req <= pkt.seq;
					now_seconds  <= pkt.now;
					offer = 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 12);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
			in_valid <= offer;
		end
	end

	// Receiver: check each result word, stall on a rotating pattern
	always @(posedge clk or negedge arst_n) begin : watch_proc
		verdict_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("unexpected result", {30'd0, status}, 32'd0);
				end else begin
					want = verdict_q.pop_front();
					if (status !== want.status)
						report_mismatch("status", {30'd0, status}, {30'd0, want.status});
					if (stored_sequence !== want.seq)
						report_mismatch("stored_sequence", stored_sequence, want.seq);
				end
				results_seen++;
				// hold off for a long stretch so the block backs up into its input
				if (results_seen == 300 || results_seen == 800)
					hold_left = 2500;
			end
			if (hold_left != 0)
				hold_left--;
			pat_age++;
			if (pat_age >= 64) begin
				pat_age   = 0;
				ready_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
			end else begin
				ready_pat = {ready_pat[0], ready_pat[7:1]};
			end
			out_ready <= (hold_left == 0) && ready_pat[0];
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic add_packet(input logic [31:0] addr, input logic [15:0] port,
			input logic signed [31:0] seq, input logic [31:0] now);
		packet_t p;
		p.addr = addr;
		p.port = port;
		p.seq  = seq;
		p.now  = now;
		packet_q.push_back(p);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (packet_q.size() != 0 || in_valid || verdict_q.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_expiry(input logic [15:0] value);
		@(posedge clk);
		cfg_we       <= 1'b1;
		cfg_wdata    <= value;
		expiry_model = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly known clients with nearly ordered sequences, some strangers and noise
	task automatic add_random_phase(input int count);
		int k;
		int r;
		int idx;
		logic signed [31:0] seq;
		for (k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 85)
				clock_s += $urandom_range(0, 3);
			else if (r < 93)
				clock_s += expiry_model + $urandom_range(0, 40);
			else if (r < 97)
				clock_s -= $urandom_range(1, 200);
			else
				clock_s = $urandom;
			r = $urandom_range(0, 99);
			if (r < 80) begin
				idx = $urandom_range(0, ENTRIES - 1);
				r   = $urandom_range(0, 9);
				if (r < 7)
					seq = roster_seq[idx] + $urandom_range(0, 4);
				else if (r < 9)
					seq = roster_seq[idx] - $urandom_range(1, 6);
				else
					seq = $urandom;
				roster_seq[idx] = seq;
				add_packet(roster_addr[idx], roster_port[idx], seq, clock_s);
			end else if (r < 95) begin
				add_packet($urandom, 16'($urandom), $urandom, clock_s);
			end else begin
				add_packet($urandom, 16'($urandom), $urandom, $urandom);
			end
		end
	endtask

	initial begin : main_proc
		int k;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ordering, staleness at the reset expiry, wrap, fill
		roster_addr[0] = 32'h0000_0000;
		roster_port[0] = 16'h0000;
		roster_addr[1] = 32'hFFFF_FFFF;
		roster_port[1] = 16'hFFFF;
		roster_addr[2] = 32'h0000_0000;
		roster_port[2] = 16'hFFFF;
		roster_addr[3] = 32'hFFFF_FFFF;
		roster_port[3] = 16'h0000;
		add_packet(roster_addr[0], roster_port[0], 32'sh8000_0000, 32'd0);
		add_packet(roster_addr[0], roster_port[0], 32'sd5, 32'd10);
		add_packet(roster_addr[0], roster_port[0], 32'sd3, 32'd20);
		add_packet(roster_addr[0], roster_port[0], 32'sd3, 32'd130);
		add_packet(roster_addr[1], roster_port[1], 32'sh7FFF_FFFF, 32'd130);
		add_packet(roster_addr[1], roster_port[1], -32'sd1, 32'd131);
		// time going backwards looks like a huge age
		add_packet(roster_addr[1], roster_port[1], -32'sd5, 32'd100);
		add_packet(roster_addr[0], roster_port[0], -32'sd1, 32'd101);
		add_packet(roster_addr[2], roster_port[2], 32'sd0, 32'd102);
		add_packet(roster_addr[3], roster_port[3], 32'sd1, 32'd102);
		for (k = 4; k < ENTRIES; k++) begin
			roster_addr[k] = $urandom;
			roster_port[k] = 16'($urandom);
			roster_seq[k]  = $urandom;
			add_packet(roster_addr[k], roster_port[k], roster_seq[k], 32'd99 + k);
		end
		roster_seq[0] = -32'sd1;
		roster_seq[1] = -32'sd5;
		roster_seq[2] = 32'sd0;
		roster_seq[3] = 32'sd1;
		// table full; every other entry is stale here
		add_packet(32'h0A00_0001, 16'd5000, 32'sd9, 32'd300);
		wait_drained();

		// Zero expiry: every entry is stale
		write_expiry(16'd0);
		add_packet(roster_addr[0], roster_port[0], -32'sd100, 32'd300);
		add_packet(32'h0A00_0002, 16'd5001, 32'sd10, 32'd300);
		roster_seq[0] = -32'sd100;
		clock_s = 32'd300;
		wait_drained();

		// Random phases across expiry settings, the extremes among them
		write_expiry(16'hFFFF);
		add_random_phase(PHASE_ITEMS);
		wait_drained();
		write_expiry(16'd30);
		add_random_phase(PHASE_ITEMS);
		wait_drained();
		write_expiry(16'd1);
		add_random_phase(PHASE_ITEMS);
		wait_drained();
		write_expiry(16'($urandom_range(2, 600)));
		add_random_phase(PHASE_ITEMS);
		wait_drained();
		write_expiry(16'd0);
		add_random_phase(PHASE_ITEMS);
		wait_drained();

		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/cst_pkg.sv
hw/rtl/cst_cell.sv
hw/rtl/client_sequence_tracker_core.sv
sim/tb_client_sequence_tracker_core.sv
